// ===== sv/scrc_pkg.sv =====
// Shared types and constants for the serial clock/RAM chip.
package scrc_pkg;

   localparam int MEM_DEPTH = 32;
   localparam int ADDR_W    = 5;
   localparam int BYTE_W    = 8;
   localparam int POS_W     = 5;
   localparam int CMD_W     = 16;

   // Command word layout
   localparam int READ_BIT  = 15;
   localparam int ADDR_HI   = 14;
   localparam int ADDR_LO   = 10;

   localparam logic [POS_W-1:0] POS_READ_MERGE = 5'd8;
   localparam logic [POS_W-1:0] POS_LAST_BIT   = 5'd15;
   localparam logic [POS_W-1:0] POS_LIMIT      = 5'd16;

   // Tick copies the counter bytes into the shadow bytes above them
   localparam int TIME_BYTES = 4;

   typedef enum logic [1:0] {
      CMD_PIN  = 2'd0,
      CMD_TICK = 2'd1,
      CMD_LOAD = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      MEM_IDLE  = 2'd0,
      MEM_TICK  = 2'd1,
      MEM_WRITE = 2'd2
   } mem_kind_type;

   typedef struct packed {
      mem_kind_type            kind;
      logic [ADDR_W-1:0]       addr;
      logic [BYTE_W-1:0]       data;
   } mem_req_type;

   typedef struct packed {
      logic [1:0]              cmd;
      logic                    enable_pin;
      logic                    data_pin;
      logic                    clock_pin;
      logic [ADDR_W-1:0]       load_addr;
      logic [BYTE_W-1:0]       load_data;
   } item_type;

   typedef struct packed {
      logic                    data_out;
      logic                    write_done;
      logic [ADDR_W-1:0]       write_addr;
      logic [BYTE_W-1:0]       write_data;
   } result_type;

endpackage

// ===== sv/scrc_if.sv =====
// Valid/ready channel interfaces for request and response items.
interface scrc_req_if import scrc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic              enable_pin;
   logic              data_pin;
   logic              clock_pin;
   logic [ADDR_W-1:0] load_addr;
   logic [BYTE_W-1:0] load_data;

   modport source (output valid, cmd, enable_pin, data_pin, clock_pin, load_addr, load_data,
                   input ready);
   modport sink   (input valid, cmd, enable_pin, data_pin, clock_pin, load_addr, load_data,
                   output ready);
endinterface

interface scrc_rsp_if import scrc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              data_out;
   logic              write_done;
   logic [ADDR_W-1:0] write_addr;
   logic [BYTE_W-1:0] write_data;

   modport source (output valid, data_out, write_done, write_addr, write_data, input ready);
   modport sink   (input valid, data_out, write_done, write_addr, write_data, output ready);
endinterface

// ===== sv/scrc_mem.sv =====
// 32-byte chip memory with clock tick counter and shadow copy.
module scrc_mem import scrc_pkg::*; #(
   parameter int TICK_BYTES = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  mem_req_type       mem_req,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem_ff [MEM_DEPTH];
   logic [BYTE_W-1:0] mem_in [MEM_DEPTH];
   logic [BYTE_W-1:0] tick_val [TIME_BYTES];
   logic [TIME_BYTES:0] carry;

   assign carry[0] = 1'b1;

   // little-endian counter over the low bytes
   for (genvar k = 0; k < TIME_BYTES; k++) begin : g_tick
      if (k < TICK_BYTES) begin : g_cnt
         assign tick_val[k]  = mem_ff[k] + {{(BYTE_W-1){1'b0}}, carry[k]};
         assign carry[k+1]   = carry[k] & (mem_ff[k] == {BYTE_W{1'b1}});
      end else begin : g_hold
         assign tick_val[k]  = mem_ff[k];
         assign carry[k+1]   = 1'b0;
      end
   end

   for (genvar e = 0; e < MEM_DEPTH; e++) begin : g_entry
      always_comb begin
         mem_in[e] = mem_ff[e];
         if (mem_req.kind == MEM_WRITE && mem_req.addr == ADDR_W'(e)) begin
            mem_in[e] = mem_req.data;
         end else if (mem_req.kind == MEM_TICK) begin
            if (e < TIME_BYTES) begin
               mem_in[e] = tick_val[e % TIME_BYTES];
            end else if (e < 2 * TIME_BYTES) begin
               mem_in[e] = tick_val[e % TIME_BYTES];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            mem_ff[e] <= '0;
         end else begin
            mem_ff[e] <= mem_in[e];
         end
      end
   end

   assign rd_data = mem_ff[rd_addr];

endmodule

// ===== sv/scrc_ctrl.sv =====
// Command shifter: pin edge detect, command assembly, read merge and write decode.
module scrc_ctrl import scrc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  item_type          item,
   input  logic [BYTE_W-1:0] rd_data,
   output logic [ADDR_W-1:0] rd_addr,
   output mem_req_type       mem_req,
   output result_type        result
);

   logic              last_clock_ff, last_clock_in;
   logic [POS_W-1:0]  bit_pos_ff, bit_pos_in;
   logic [CMD_W-1:0]  cmd_word_ff, cmd_word_in;

   logic              pos_active;
   logic              shift_ok;
   logic              rising;
   logic [3:0]        bit_idx;
   logic [CMD_W-1:0]  word_shift;
   logic [CMD_W-1:0]  word_merge;

   assign pos_active = bit_pos_ff < POS_LIMIT;
   assign bit_idx    = ~bit_pos_ff[3:0];
   assign rising     = item.clock_pin & ~last_clock_ff;
   assign shift_ok   = (bit_pos_ff < POS_READ_MERGE) | (pos_active & ~cmd_word_ff[READ_BIT]);

   always_comb begin
      word_shift = cmd_word_ff;
      if (shift_ok && item.data_pin) begin
         word_shift[bit_idx] = 1'b1;
      end
   end

   assign rd_addr = word_shift[ADDR_HI:ADDR_LO];

   always_comb begin
      word_merge = word_shift;
      if (word_shift[READ_BIT] && bit_pos_ff == POS_READ_MERGE) begin
         word_merge[BYTE_W-1:0] = word_shift[BYTE_W-1:0] | rd_data;
      end
   end

   always_comb begin
      last_clock_in = last_clock_ff;
      bit_pos_in    = bit_pos_ff;
      cmd_word_in   = cmd_word_ff;
      mem_req       = '{kind: MEM_IDLE, addr: '0, data: '0};
      result        = '0;
      unique case (cmd_type'(item.cmd))
         CMD_PIN: begin
            last_clock_in = item.clock_pin;
            if (item.enable_pin) begin
               bit_pos_in  = '0;
               cmd_word_in = '0;
            end else if (rising) begin
               cmd_word_in = word_merge;
               if (pos_active) begin
                  bit_pos_in = bit_pos_ff + POS_W'(1);
               end
               if (word_shift[READ_BIT]) begin
                  result.data_out = pos_active & word_merge[bit_idx];
               end else if (bit_pos_ff == POS_LAST_BIT) begin
                  result.write_done = 1'b1;
                  result.write_addr = rd_addr;
                  result.write_data = word_shift[BYTE_W-1:0];
                  mem_req = '{kind: MEM_WRITE, addr: rd_addr, data: word_shift[BYTE_W-1:0]};
               end
            end
         end
         CMD_TICK: begin
            mem_req.kind = MEM_TICK;
         end
         CMD_LOAD: begin
            mem_req = '{kind: MEM_WRITE, addr: item.load_addr, data: item.load_data};
         end
         default: begin
         end
      endcase
      if (!fire) begin
         mem_req.kind = MEM_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_clock_ff <= 1'b0;
         bit_pos_ff    <= '0;
         cmd_word_ff   <= '0;
      end else if (fire) begin
         last_clock_ff <= last_clock_in;
         bit_pos_ff    <= bit_pos_in;
         cmd_word_ff   <= cmd_word_in;
      end
   end

   // a write report never carries a read bit
   a_write_no_data: assert property (@(posedge clock) disable iff (reset)
      result.write_done |-> !result.data_out)
      else $error("write report with data bit set");

   // bit position saturates at sixteen
   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      bit_pos_ff <= POS_LIMIT)
      else $error("bit position past limit");

   // a bit position only moves on a pin item taken by the pipe
   a_pos_moves: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(bit_pos_ff) && $stable(cmd_word_ff))
      else $error("shifter state changed without an item");

endmodule

// ===== sv/serial_clock_ram_chip_top.sv =====
// Top level of the serial clock/RAM chip: item register, shifter, memory, result register.
//
// Serial clock/RAM chip with 32 bytes of battery memory.
// req_ch (sink): one item per handshake. cmd 0 is a sample of the enable,
//   data and clock pins; cmd 1 is a one-second tick that advances the low
//   TICK_BYTES bytes as a counter and copies bytes 0..3 into 4..7; cmd 2
//   presets one memory byte. cmd 3 is ignored and answers with zeros.
// rsp_ch (source): exactly one item per request item, in order: the serial
//   data bit returned on a read edge, and a report of any byte stored by a
//   serial write so the host side can save it.
// An accepted item waits in the item register until the result register can
//   take it; the shifter and memory then process it into the result register.
// Throughput: one item per cycle unless rsp_ch stalls; all per-item work is
//   a single pass of shift, one byte read and the tick carry chain between two registers.
// When rsp_ch is stalled the result register holds, the item register
//   still takes one more item, and then req_ch.ready drops until the
//   result is taken.
// Reset (synchronous, active high) clears both pipeline stages, the pin
//   edge detector, the command shifter and all 32 memory bytes at once.
module serial_clock_ram_chip_top import scrc_pkg::*; #(
   parameter int TICK_BYTES = 3
) (
   input  logic       clock,
   input  logic       reset,
   scrc_req_if.sink   req_ch,
   scrc_rsp_if.source rsp_ch
);

   // input stage
   logic        s1_valid_ff, s1_valid_in;
   item_type    s1_item_ff;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_res_ff;

   logic              adv;
   logic              fire;
   logic              req_take;
   result_type        result;
   mem_req_type       mem_req;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;

   // the result stage can take a new result when empty or being drained
   assign adv      = !rsp_valid_ff || rsp_ch.ready;
   assign fire     = s1_valid_ff && adv;
   assign req_ch.ready = !s1_valid_ff || adv;
   assign req_take = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= '{cmd:        req_ch.cmd,
                         enable_pin: req_ch.enable_pin,
                         data_pin:   req_ch.data_pin,
                         clock_pin:  req_ch.clock_pin,
                         load_addr:  req_ch.load_addr,
                         load_data:  req_ch.load_data};
      end
      if (fire) begin
         rsp_res_ff <= result;
      end
   end

   scrc_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (s1_item_ff),
      .rd_data (rd_data),
      .rd_addr (rd_addr),
      .mem_req (mem_req),
      .result  (result)
   );

   scrc_mem #(
      .TICK_BYTES (TICK_BYTES)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.data_out   = rsp_res_ff.data_out;
   assign rsp_ch.write_done = rsp_res_ff.write_done;
   assign rsp_ch.write_addr = rsp_res_ff.write_addr;
   assign rsp_ch.write_data = rsp_res_ff.write_data;

   // both stages full and output stalled: no room for another item
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("item taken with pipeline full");

   // an accepted item always lands in the input stage
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted item lost");

   // a new result only appears after an item was processed
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result without an item");

endmodule

// ===== dv/scrc_result_checker.sv =====
// Result checker for the serial clock/RAM chip: tracks chip state and compares every result.
module scrc_result_checker import scrc_pkg::*; #(
   parameter int TICK_BYTES = 3
) (
   input  logic clock,
   input  logic reset,
   scrc_req_if  req_ch,
   scrc_rsp_if  rsp_ch,
   output int   mismatches,
   output int   outstanding
);

   logic              clk_seen;
   logic [POS_W-1:0]  shift_pos;
   logic [CMD_W-1:0]  cmd_word;
   logic [BYTE_W-1:0] chip_bytes [MEM_DEPTH];
   result_type        results_due [$];
   int                result_index;

   initial begin
      mismatches   = 0;
      outstanding  = 0;
      result_index = 0;
   end

   // Applies one item to the tracked chip state and returns the result it owes.
   function automatic result_type chip_respond(item_type it);
      result_type r;
      int         p;
      int         k;
      logic       carry;
      r = '0;
      case (it.cmd)
         CMD_PIN: begin
            if (it.enable_pin) begin
               shift_pos = '0;
               cmd_word  = '0;
            end else if (it.clock_pin && !clk_seen) begin
               p = shift_pos;
               // read commands stop taking host bits once the byte is merged
               if (p < POS_READ_MERGE || (p < POS_LIMIT && !cmd_word[READ_BIT])) begin
                  if (it.data_pin)
                     cmd_word[CMD_W-1-p] = 1'b1;
               end
               if (cmd_word[READ_BIT]) begin
                  if (p == POS_READ_MERGE)
                     cmd_word[BYTE_W-1:0] = cmd_word[BYTE_W-1:0] |
                                            chip_bytes[cmd_word[ADDR_HI:ADDR_LO]];
                  if (p < POS_LIMIT)
                     r.data_out = cmd_word[CMD_W-1-p];
               end else if (p == POS_LAST_BIT) begin
                  r.write_done = 1'b1;
                  r.write_addr = cmd_word[ADDR_HI:ADDR_LO];
                  r.write_data = cmd_word[BYTE_W-1:0];
                  chip_bytes[r.write_addr] = r.write_data;
               end
               // position saturates at sixteen
               if (p < POS_LIMIT)
                  shift_pos = POS_W'(p + 1);
            end
            clk_seen = it.clock_pin;
         end
         CMD_TICK: begin
            carry = 1'b1;
            for (k = 0; k < TICK_BYTES && k < TIME_BYTES; k++) begin
               if (carry) begin
                  chip_bytes[k] = chip_bytes[k] + 8'd1;
                  carry = (chip_bytes[k] == 8'd0);
               end
            end
            for (k = 0; k < TIME_BYTES; k++)
               chip_bytes[k + TIME_BYTES] = chip_bytes[k];
         end
         CMD_LOAD: chip_bytes[it.load_addr] = it.load_data;
         default: ;
      endcase
      return r;
   endfunction

   task automatic flag_mismatch(string what, int got, int want);
      $display("result %0d: %s is %0d, expected %0d", result_index, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      item_type   it;
      result_type got;
      result_type want;
      int         k;
      if (reset) begin
         clk_seen  = 1'b0;
         shift_pos = '0;
         cmd_word  = '0;
         for (k = 0; k < MEM_DEPTH; k++)
            chip_bytes[k] = '0;
         results_due.delete();
      end else begin
         // results first, so a result never matches an item taken at the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.data_out   = rsp_ch.data_out;
            got.write_done = rsp_ch.write_done;
            got.write_addr = rsp_ch.write_addr;
            got.write_data = rsp_ch.write_data;
            if (results_due.size() == 0) begin
               flag_mismatch("unexpected item, pending count", 1, 0);
            end else begin
               want = results_due.pop_front();
               if (got.data_out !== want.data_out)
                  flag_mismatch("data_out", got.data_out, want.data_out);
               if (got.write_done !== want.write_done)
                  flag_mismatch("write_done", got.write_done, want.write_done);
               if (got.write_addr !== want.write_addr)
                  flag_mismatch("write_addr", got.write_addr, want.write_addr);
               if (got.write_data !== want.write_data)
                  flag_mismatch("write_data", got.write_data, want.write_data);
            end
            result_index++;
         end
         if (req_ch.valid && req_ch.ready) begin
            it.cmd        = req_ch.cmd;
            it.enable_pin = req_ch.enable_pin;
            it.data_pin   = req_ch.data_pin;
            it.clock_pin  = req_ch.clock_pin;
            it.load_addr  = req_ch.load_addr;
            it.load_data  = req_ch.load_data;
            results_due.push_back(chip_respond(it));
         end
      end
      outstanding = results_due.size();
   end

endmodule

// ===== dv/testbench.sv =====
// Top of the serial clock/RAM chip testbench: clock, reset, stimulus, receiver and verdict.
module testbench;
   import scrc_pkg::*;

   localparam int         TICK_BYTES     = 3;
   localparam logic [1:0] CMD_UNUSED     = 2'd3;   // not decoded by the chip
   localparam int         RANDOM_ITEMS   = 1400;
   localparam int         DRAIN_EVERY    = 400;    // sender waits for all results this often
   localparam int         HOLD_AFTER     = 600;    // random items before the long receiver hold
   localparam int         LONG_HOLD      = 400;    // cycles the receiver holds off
   localparam int         WATCHDOG_LIMIT = 3000;   // cycles without any handshake
   localparam int         SETTLE_CYCLES  = 4;      // settling wait before the verdict
   localparam int         NO_ABORT       = 16;

   typedef enum {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_style_type;

   logic       clock;
   logic       reset;
   int         mismatches;
   int         outstanding;

   // sender bookkeeping
   int         items_sent;
   int         burst_left;
   int         gap_max;
   bit         want_hold;

   // receiver bookkeeping
   bit           hold_taken = 1'b0;
   int           hold_left  = 0;
   int           rx_left    = 0;
   int           rx_count   = 0;
   rx_style_type rx_style   = RX_STEADY;

   int         idle_cycles;

   scrc_req_if req_ch();
   scrc_rsp_if rsp_ch();

   serial_clock_ram_chip_top #(.TICK_BYTES(TICK_BYTES)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   scrc_result_checker #(.TICK_BYTES(TICK_BYTES)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Sender. Items go out in bursts; between bursts valid drops for a
   // random gap of up to gap_max cycles (gap_max = 0 means back to back).
   // Inputs move on the falling edge, ready is looked at on the rising one.
   // ------------------------------------------------------------------
   task automatic send(item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid      = 1'b1;
      req_ch.cmd        = it.cmd;
      req_ch.enable_pin = it.enable_pin;
      req_ch.data_pin   = it.data_pin;
      req_ch.clock_pin  = it.clock_pin;
      req_ch.load_addr  = it.load_addr;
      req_ch.load_data  = it.load_data;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Pin sample; the preload fields are junk here and get random values.
   task automatic pin(bit en, bit dat, bit clk);
      item_type it;
      it.cmd        = CMD_PIN;
      it.enable_pin = en;
      it.data_pin   = dat;
      it.clock_pin  = clk;
      it.load_addr  = ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
      it.load_data  = BYTE_W'($urandom_range(0, 255));
      send(it);
   endtask

   task automatic other_item(logic [1:0] cmd, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
      item_type it;
      it.cmd        = cmd;
      it.enable_pin = 1'($urandom_range(0, 1));
      it.data_pin   = 1'($urandom_range(0, 1));
      it.clock_pin  = 1'($urandom_range(0, 1));
      it.load_addr  = addr;
      it.load_data  = data;
      send(it);
   endtask

   // Stray item dropped into the middle of a serial command: must not
   // disturb the shifter or the clock edge detector.
   task automatic side_item();
      case ($urandom_range(0, 2))
         0:       other_item(CMD_TICK, ADDR_W'($urandom_range(0, 31)),
                             BYTE_W'($urandom_range(0, 255)));
         1:       other_item(CMD_LOAD, ADDR_W'($urandom_range(0, 31)),
                             BYTE_W'($urandom_range(0, 255)));
         default: other_item(CMD_UNUSED, ADDR_W'($urandom_range(0, 31)),
                             BYTE_W'($urandom_range(0, 255)));
      endcase
   endtask

   // Full host transaction: select, a clock pulse for each of the CMD_W bits, MSB first, optional
   // pulses past the end (saturation), deselect. abort_at < 16 raises
   // enable in the middle to break the command off.
   task automatic serial_command(logic [CMD_W-1:0] word, int abort_at, int extra);
      int i;
      bit broken;
      broken = 1'b0;
      pin(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (i = CMD_W - 1; i >= 0 && !broken; i--) begin
         if (CMD_W - 1 - i == abort_at) begin
            broken = 1'b1;
         end else begin
            if ($urandom_range(0, 39) == 0)
               side_item();
            pin(1'b0, 1'($urandom_range(0, 1)), 1'b0);
            if ($urandom_range(0, 19) == 0)
               side_item();
            pin(1'b0, word[i], 1'b1);
            // clock held high: no new rising edge
            if ($urandom_range(0, 19) == 0)
               pin(1'b0, 1'($urandom_range(0, 1)), 1'b1);
         end
      end
      if (!broken) begin
         repeat (extra) begin
            pin(1'b0, 1'($urandom_range(0, 1)), 1'b0);
            pin(1'b0, 1'($urandom_range(0, 1)), 1'b1);
         end
      end
      pin(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // Stop offering items until every result owed has come back.
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      wait (outstanding == 0);
      burst_left = 0;
   endtask

   // ------------------------------------------------------------------
   // Receiver: switches between steady, random, periodic and sparse
   // ready patterns. Once the sender asks for it, ready is held low
   // so the two pipeline stages fill and req ready drops.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready = 1'b0;
      end else if (want_hold && !hold_taken) begin
         hold_taken   = 1'b1;
         hold_left    = LONG_HOLD - 1;
         rsp_ch.ready = 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_style = rx_style_type'($urandom_range(0, 3));
            rx_left  = $urandom_range(64, 256);
         end
         rx_left--;
         rx_count++;
         case (rx_style)
            RX_STEADY:   rsp_ch.ready = 1'b1;
            RX_RANDOM:   rsp_ch.ready = ($urandom_range(0, 9) < 7);
            RX_PERIODIC: rsp_ch.ready = (rx_count % 4 != 0);
            default:     rsp_ch.ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Watchdog: any long stretch with no handshake on either side is a hang.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int               first_random;
      int               next_drain;
      int               choice;
      int               k;
      logic [CMD_W-1:0] word;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.cmd        = CMD_PIN;
      req_ch.enable_pin = 1'b0;
      req_ch.data_pin   = 1'b0;
      req_ch.clock_pin  = 1'b0;
      req_ch.load_addr  = '0;
      req_ch.load_data  = '0;
      rsp_ch.ready      = 1'b0;
      items_sent        = 0;
      burst_left        = 0;
      gap_max           = 0;
      want_hold         = 1'b0;
      idle_cycles       = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed part ---
      // unused command with address and data at their top values
      other_item(CMD_UNUSED, 5'd31, 8'hFF);
      // carry runs through all counter bytes and stops short of byte 3
      other_item(CMD_LOAD, 5'd0, 8'hFF);
      other_item(CMD_LOAD, 5'd1, 8'hFF);
      other_item(CMD_LOAD, 5'd2, 8'hFF);
      other_item(CMD_LOAD, 5'd3, 8'h5A);
      other_item(CMD_TICK, 5'd0, 8'h00);
      other_item(CMD_TICK, 5'd31, 8'hFF);
      // top address, both extreme values
      other_item(CMD_LOAD, 5'd31, 8'h00);
      other_item(CMD_LOAD, 5'd31, 8'hFF);
      // enable high with a clock rise: shifter cleared, edge ignored
      pin(1'b1, 1'b1, 1'b1);
      // enable drops with clock already high: no edge
      pin(1'b0, 1'b1, 1'b1);
      // real rising edge shifts a read bit and returns it
      pin(1'b0, 1'b0, 1'b0);
      pin(1'b0, 1'b1, 1'b1);
      // tick and preload leave the edge detector alone
      pin(1'b0, 1'b0, 1'b0);
      other_item(CMD_TICK, 5'd0, 8'h00);
      other_item(CMD_LOAD, 5'd4, 8'hA5);
      pin(1'b0, 1'b0, 1'b1);
      pin(1'b0, 1'b1, 1'b1);
      pin(1'b1, 1'b0, 1'b0);
      drain_results();

      // --- random part ---
      first_random = items_sent;
      next_drain   = items_sent + DRAIN_EVERY;
      while (items_sent - first_random < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0:       gap_max = 0;
               1:       gap_max = 3;
               default: gap_max = 12;
            endcase
         end
         // long receiver hold while the sender keeps pushing
         if (!want_hold && items_sent - first_random >= HOLD_AFTER) begin
            gap_max   = 0;
            want_hold = 1'b1;
         end
         if (items_sent >= next_drain) begin
            drain_results();
            next_drain += DRAIN_EVERY;
         end

         choice = $urandom_range(0, 99);
         if (choice < 65) begin
            // well-formed command, bias addresses toward the clock bytes
            word = CMD_W'($urandom_range(0, 16'hFFFF));
            if ($urandom_range(0, 2) == 0)
               word[ADDR_HI:ADDR_LO] = ADDR_W'($urandom_range(0, 2 * TIME_BYTES - 1));
            serial_command(word,
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : NO_ABORT,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
         end else if (choice < 85) begin
            // pin noise, mostly with enable low so edges land anywhere
            repeat ($urandom_range(1, 12))
               pin(($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
         end else if (choice < 93) begin
            // set up long carries, then tick
            for (k = 0; k < TIME_BYTES; k++)
               if ($urandom_range(0, 1) == 0)
                  other_item(CMD_LOAD, ADDR_W'(k),
                             ($urandom_range(0, 1) == 0) ? 8'hFF :
                                                           BYTE_W'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 4))
               other_item(CMD_TICK, ADDR_W'($urandom_range(0, 31)),
                          BYTE_W'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4))
               side_item();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/scrc_pkg.sv
sv/scrc_if.sv
sv/scrc_mem.sv
sv/scrc_ctrl.sv
sv/serial_clock_ram_chip_top.sv
dv/scrc_result_checker.sv
dv/testbench.sv
